// ----- rtl/core/fan_mode_lease_controller_assert.svh -----
// assertion macros used by the fan mode lease controller fan bank
`ifndef FAN_MODE_LEASE_CONTROLLER_ASSERT_SVH
`define FAN_MODE_LEASE_CONTROLLER_ASSERT_SVH

// invariant checked on every clock edge outside reset
`define FMLC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant failed");

// consequence checked in the cycle after the trigger
`define FMLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/fmlc_pkg.sv -----
// types, codes and duty scaling helpers for the fan mode lease controller
`default_nettype none
package fmlc_pkg;

  localparam int NUM_FANS_DEF = 2;
  localparam int DUTY_W       = 7;
  localparam int LEASE_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [LEASE_W-1:0] LEASE_RESET = 16'd5000;

  // request codes
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_DUTY_WR = 3'd1;
  localparam logic [2:0] REQ_MODE_WR = 3'd2;
  localparam logic [2:0] REQ_DUTY_RD = 3'd3;
  localparam logic [2:0] REQ_MODE_RD = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  // fan modes
  localparam logic [1:0] MODE_TURBO  = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  localparam logic [8:0] DUTY_IN_MAX = 9'd255;
  localparam logic [8:0] MODE_MAX    = 9'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITES_EN   = 2'd1;

  typedef struct packed {
    logic [2:0] req_type;
    logic       channel;
    logic [8:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic       expired;
  } rsp_t;

  typedef struct packed {
    logic [LEASE_W-1:0] lease_ticks;
    logic               writes_enabled;
  } cfg_t;

  // v*100/255 for v in 0..255, reciprocal form exact below 2^16
  function automatic logic [DUTY_W-1:0] duty_to_raw(input logic [7:0] v);
    logic [14:0] x;
    logic [15:0] s;
    x = 15'({7'd0, v} * 15'd100);
    s = 16'(x) + 16'(x[14:8]) + 16'd1;
    return s[14:8];
  endfunction

  // r*255/100, low eight bits; 5243/2^19 is exact for products below 2^15
  function automatic logic [7:0] raw_to_duty(input logic [DUTY_W-1:0] r);
    logic [14:0] y;
    logic [27:0] p;
    y = ({8'd0, r} << 8) - {8'd0, r};
    p = 28'(y) * 28'd5243;
    return p[26:19];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fmlc_cfg_regs.sv -----
// configuration registers: lease length and write enable
`default_nettype none
module fmlc_cfg_regs import fmlc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [LEASE_W-1:0] lease_ticks;
  logic               writes_enabled;

  assign cfg_ready = 1'b1;
  assign cfg       = '{lease_ticks: lease_ticks, writes_enabled: writes_enabled};

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_ticks    <= LEASE_RESET;
      writes_enabled <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEASE_TICKS: lease_ticks    <= cfg_data[LEASE_W-1:0];
        CFG_WRITES_EN:   writes_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fmlc_fan_bank.sv -----
// per-fan state with the single-pass request decode, lease and expiry logic
`default_nettype none
`include "fan_mode_lease_controller_assert.svh"
module fmlc_fan_bank import fmlc_pkg::*; #(
  parameter int NUM_FANS = NUM_FANS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output rsp_t      rsp
);

  logic [DUTY_W-1:0]  duty        [NUM_FANS];
  logic [1:0]         mode        [NUM_FANS];
  logic [NUM_FANS-1:0] active;
  logic [LEASE_W-1:0] left        [NUM_FANS];

  logic [DUTY_W-1:0]  duty_next   [NUM_FANS];
  logic [1:0]         mode_next   [NUM_FANS];
  logic [NUM_FANS-1:0] active_next;
  logic [LEASE_W-1:0] left_next   [NUM_FANS];

  logic [LEASE_W-1:0] left_dec    [NUM_FANS];
  logic               ch_ok, is_tick, is_write, req_bad, we, chk_expiry, due;
  logic               val_ok, apply;
  logic [DUTY_W-1:0]  sel_duty;
  logic [1:0]         sel_mode;
  logic [DUTY_W-1:0]  new_duty;
  logic               lease_mode_ok, duty_ok;

  assign we       = cfg.writes_enabled;
  assign is_tick  = (req.req_type == REQ_TICK);
  assign is_write = (req.req_type == REQ_DUTY_WR) || (req.req_type == REQ_MODE_WR);
  assign ch_ok    = (int'(req.channel) < NUM_FANS);
  assign req_bad  = (req.req_type > REQ_MODE_RD) || (!is_tick && !ch_ok);
  assign new_duty = duty_to_raw(req.value[7:0]);
  assign val_ok   = (req.req_type == REQ_DUTY_WR) ? (req.value <= DUTY_IN_MAX)
                                                  : (req.value <= MODE_MAX);
  assign apply    = is_write && !req_bad && we && val_ok;

  // ticks count down first, writes check the leases as they stand
  assign chk_expiry = we && (is_tick || (is_write && !req_bad));

  always_comb begin
    due      = 1'b0;
    sel_duty = '0;
    sel_mode = '0;
    for (int i = 0; i < NUM_FANS; i++) begin
      left_dec[i] = (is_tick && we && active[i] && (left[i] != '0)) ?
                    left[i] - LEASE_W'(1) : left[i];
      if (chk_expiry && active[i] && (left_dec[i] == '0))
        due = 1'b1;
      if (i == int'(req.channel)) begin
        sel_duty = duty[i];
        sel_mode = mode[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_FANS; i++) begin
      duty_next[i]   = duty[i];
      mode_next[i]   = due ? MODE_AUTO : mode[i];
      active_next[i] = due ? 1'b0 : active[i];
      left_next[i]   = due ? '0 : left_dec[i];
      if (apply && (i == int'(req.channel))) begin
        if (req.req_type == REQ_DUTY_WR) begin
          duty_next[i] = new_duty;
          if (active_next[i])
            left_next[i] = cfg.lease_ticks;
        end else begin
          mode_next[i]   = req.value[1:0];
          active_next[i] = (req.value[1:0] == MODE_MANUAL);
          left_next[i]   = (req.value[1:0] == MODE_MANUAL) ? cfg.lease_ticks : '0;
        end
      end
    end
  end

  always_comb begin
    rsp.status    = ST_OK;
    rsp.read_data = '0;
    rsp.expired   = due;
    priority if (is_tick) begin
      rsp.status = ST_OK;
    end else if (req_bad) begin
      rsp.status = ST_INVALID;
    end else if (req.req_type == REQ_DUTY_RD) begin
      rsp.read_data = raw_to_duty(sel_duty);
    end else if (req.req_type == REQ_MODE_RD) begin
      rsp.read_data = {6'd0, sel_mode};
    end else if (!we) begin
      rsp.status = ST_BUSY;
    end else if (!val_ok) begin
      rsp.status = ST_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < NUM_FANS; i++) begin
        duty[i] <= '0;
        mode[i] <= MODE_AUTO;
        left[i] <= '0;
      end
    end else if (fire) begin
      active <= active_next;
      for (int i = 0; i < NUM_FANS; i++) begin
        duty[i] <= duty_next[i];
        mode[i] <= mode_next[i];
        left[i] <= left_next[i];
      end
    end
  end

  always_comb begin
    lease_mode_ok = 1'b1;
    duty_ok       = 1'b1;
    for (int i = 0; i < NUM_FANS; i++) begin
      if (active[i] && (mode[i] != MODE_MANUAL))
        lease_mode_ok = 1'b0;
      if (duty[i] > DUTY_W'(100))
        duty_ok = 1'b0;
    end
  end

  `FMLC_ASSERT_ALWAYS(a_lease_only_in_manual, lease_mode_ok)
  `FMLC_ASSERT_ALWAYS(a_duty_in_range, duty_ok)
  `FMLC_ASSERT_NEXT(a_tick_expiry_clears, fire && is_tick && due, active == '0)
  `FMLC_ASSERT_NEXT(a_busy_keeps_leases, fire && (rsp.status == ST_BUSY), $stable(active))

endmodule
`default_nettype wire

// ----- rtl/core/fmlc_out_reg.sv -----
// result register between the fan bank and the response channel
`default_nettype none
module fmlc_out_reg import fmlc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire rsp_t rsp_in,
  output logic      load_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  logic valid;
  rsp_t data;

  // a waiting result leaves in the same cycle a new one is loaded
  assign load_ready = !valid || rsp_ready;
  assign rsp_valid  = valid;
  assign rsp        = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      data <= rsp_in;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fan_mode_lease_controller.sv -----
// top level: fan mode and lease controller
//
//   channel  handshake             payload
//   req      req_valid/req_ready   req (req_type, channel, value)
//   rsp      rsp_valid/rsp_ready   rsp (status, read_data, expired)
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// every request is decoded and applied to the fan state in the cycle it is
// accepted, one per clock while the result register can take it; its result is
// written to that register at the same edge; a new request is taken whenever
// that register is empty or its result is taken in the same cycle
// synchronous reset restores auto mode, zero duty, no leases, lease length 5000
// cfg writes are taken every cycle
`default_nettype none
module fan_mode_lease_controller import fmlc_pkg::*; #(
  parameter int NUM_FANS = NUM_FANS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire req_t                  req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output rsp_t                       rsp,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  rsp_t rsp_comb;
  logic fire;

  assign fire = req_valid && req_ready;

  fmlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fmlc_fan_bank #(.NUM_FANS(NUM_FANS)) u_bank (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .cfg  (cfg),
    .rsp  (rsp_comb)
  );

  fmlc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (req_valid),
    .rsp_in     (rsp_comb),
    .load_ready (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
`default_nettype wire
